@@ rtl/core/mmtd_pkg.sv @@
// Package for the min/max thermometer display.
// Holds the mode and register index codes, reset constants, display limits and the display word type.
// No dependencies.
`default_nettype none

package mmtd_pkg;

  typedef enum logic [1:0] {
    MODE_MAXIMUM = 2'd0,
    MODE_CURRENT = 2'd1,
    MODE_MINIMUM = 2'd2,
    MODE_SLEEP   = 2'd3
  } mode_t;

  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MINUS_CODE = 2'd0,
    CFG_BLANK_CODE = 2'd1
  } cfg_reg_t;

  localparam logic [7:0] MINUS_CODE_RST = 8'd10;
  localparam logic [7:0] BLANK_CODE_RST = 8'd11;

  localparam logic signed [7:0] CURRENT_RST = 8'sd0;
  localparam logic signed [7:0] MINIMUM_RST = 8'sd127;
  localparam logic signed [7:0] MAXIMUM_RST = -8'sd128;

  localparam logic signed [7:0] SHOW_LOW  = -8'sd9;
  localparam logic signed [7:0] SHOW_HIGH = 8'sd99;
  localparam logic signed [7:0] TWO_DIGIT = 8'sd10;

  // Reciprocal of ten scaled by 2**11; exact for values below 1029.
  localparam logic [7:0] RECIP_TEN   = 8'd205;
  localparam int         RECIP_SHIFT = 11;

  typedef struct packed {
    logic [7:0] left_char;
    logic [7:0] right_char;
    logic       led_maximum;
    logic       led_current;
    logic       led_minimum;
    logic       display_on;
  } disp_t;

endpackage

`default_nettype wire

@@ rtl/core/min_max_thermometer_display.sv @@
// Top level of the min/max thermometer display.
// Depends on mmtd_pkg and mmtd_encode.
//
// Every accepted word, a temperature sample or a button press, produces one display word in the
// next cycle. A sample updates the current, minimum and maximum values; a press steps the
// mode through maximum, current, minimum and sleep. The state update and the character
// encoding are one short combinational path into the output register, so a new word is taken
// every cycle; the input stalls only while a finished word waits in the output register and
// the output is stalled. Configuration writes are always ready and apply to words accepted later.
`default_nettype none

module min_max_thermometer_display (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               in_action,
  input  wire logic signed [7:0]                  in_temperature,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [7:0]                              out_left_char,
  output logic [7:0]                              out_right_char,
  output logic                                    out_led_maximum,
  output logic                                    out_led_current,
  output logic                                    out_led_minimum,
  output logic                                    out_display_on,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [mmtd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [7:0]                         cfg_data
);
  import mmtd_pkg::*;

  mode_t             mode_r, mode_nxt;
  logic signed [7:0] cur_r, cur_nxt;
  logic signed [7:0] min_r, min_nxt;
  logic signed [7:0] max_r, max_nxt;
  logic [7:0]        minus_r;
  logic [7:0]        blank_r;
  logic              out_valid_r;
  disp_t             disp_r;
  disp_t             disp_nxt;
  logic signed [7:0] shown;
  logic              accept;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    mode_nxt = mode_r;
    cur_nxt  = cur_r;
    min_nxt  = min_r;
    max_nxt  = max_r;
    if (in_action) begin
      unique case (mode_r)
        MODE_MAXIMUM: mode_nxt = MODE_CURRENT;
        MODE_CURRENT: mode_nxt = MODE_MINIMUM;
        MODE_MINIMUM: mode_nxt = MODE_SLEEP;
        MODE_SLEEP:   mode_nxt = MODE_MAXIMUM;
        default:      mode_nxt = MODE_CURRENT;
      endcase
    end else begin
      cur_nxt = in_temperature;
      if (in_temperature < min_r) begin
        min_nxt = in_temperature;
      end
      if (in_temperature > max_r) begin
        max_nxt = in_temperature;
      end
    end
  end

  always_comb begin
    unique case (mode_nxt)
      MODE_MAXIMUM: shown = max_nxt;
      MODE_MINIMUM: shown = min_nxt;
      default:      shown = cur_nxt;
    endcase
  end

  mmtd_encode u_encode (
    .mode       (mode_nxt),
    .shown      (shown),
    .minus_code (minus_r),
    .blank_code (blank_r),
    .disp       (disp_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_CURRENT;
      cur_r       <= CURRENT_RST;
      min_r       <= MINIMUM_RST;
      max_r       <= MAXIMUM_RST;
      minus_r     <= MINUS_CODE_RST;
      blank_r     <= BLANK_CODE_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_MINUS_CODE: minus_r <= cfg_data;
          CFG_BLANK_CODE: blank_r <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        mode_r      <= mode_nxt;
        cur_r       <= cur_nxt;
        min_r       <= min_nxt;
        max_r       <= max_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      disp_r <= disp_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left_char   = disp_r.left_char;
  assign out_right_char  = disp_r.right_char;
  assign out_led_maximum = disp_r.led_maximum;
  assign out_led_current = disp_r.led_current;
  assign out_led_minimum = disp_r.led_minimum;
  assign out_display_on  = disp_r.display_on;

endmodule

`default_nettype wire

@@ rtl/core/mmtd_encode.sv @@
// Display encoder: turns the selected value and mode into two character codes and LEDs.
// Depends on mmtd_pkg.
`default_nettype none

module mmtd_encode (
  input  var mmtd_pkg::mode_t       mode,
  input  wire logic signed [7:0]    shown,
  input  wire logic [7:0]           minus_code,
  input  wire logic [7:0]           blank_code,
  output mmtd_pkg::disp_t           disp
);
  import mmtd_pkg::*;

  logic [6:0]  mag;
  logic [14:0] prod;
  logic [3:0]  tens;
  logic [6:0]  units;
  logic [7:0]  left_c;
  logic [7:0]  right_c;

  always_comb begin
    mag   = shown[7] ? 7'(-shown) : shown[6:0];
    prod  = 15'(mag) * 15'(RECIP_TEN);
    tens  = prod[RECIP_SHIFT +: 4];
    units = mag - 7'(tens) * 7'd10;

    if ((shown < SHOW_LOW) || (shown > SHOW_HIGH)) begin
      left_c  = minus_code;
      right_c = minus_code;
    end else if (shown[7]) begin
      left_c  = minus_code;
      right_c = {1'b0, mag};
    end else if (shown >= TWO_DIGIT) begin
      left_c  = {4'd0, tens};
      right_c = {1'b0, units};
    end else begin
      left_c  = blank_code;
      right_c = {1'b0, mag};
    end
  end

  always_comb begin
    disp = '0;
    unique case (mode)
      MODE_MAXIMUM: begin
        disp.left_char   = left_c;
        disp.right_char  = right_c;
        disp.led_maximum = 1'b1;
        disp.display_on  = 1'b1;
      end
      MODE_CURRENT: begin
        disp.left_char   = left_c;
        disp.right_char  = right_c;
        disp.led_current = 1'b1;
        disp.display_on  = 1'b1;
      end
      MODE_MINIMUM: begin
        disp.left_char   = left_c;
        disp.right_char  = right_c;
        disp.led_minimum = 1'b1;
        disp.display_on  = 1'b1;
      end
      MODE_SLEEP: begin
        disp.left_char  = blank_code;
        disp.right_char = blank_code;
      end
      default: begin
        disp = '0;
      end
    endcase
  end

endmodule

`default_nettype wire
